// ===== sv/mlf_pkg.sv =====
package mlf_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int PORT_COUNT  = 4;
  localparam int MAC_W       = 48;
  localparam int PORT_W      = 2;
  localparam int MASK_W      = 4;
  localparam int TIME_W      = 32;
  localparam int LIFE_W      = 16;
  localparam int CMD_W       = 3;
  localparam int ACT_W       = 3;

  localparam logic [LIFE_W-1:0] LIFE_RESET = LIFE_W'(300);
  localparam logic [MASK_W-1:0] PORTS_ALL  = MASK_W'((1 << PORT_COUNT) - 1);
  localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_PACKET    = 3'd0,
    CMD_TICK      = 3'd1,
    CMD_PROBE     = 3'd2,
    CMD_DET_START = 3'd3,
    CMD_DET_DONE  = 3'd4
  } cmd_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE      = 3'd0,
    ACT_NOT_READY = 3'd1,
    ACT_BLOCKED   = 3'd2,
    ACT_SAME_PORT = 3'd3,
    ACT_UNICAST   = 3'd4,
    ACT_FLOOD     = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LEARN_CMP,
    ST_LEARN_WR,
    ST_LOOK_CMP,
    ST_LOOK_RES,
    ST_AGE,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_COMPARE,
    CELL_UPDATE,
    CELL_AGE
  } cell_op_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
    logic [PORT_W-1:0] in_port;
  } in_item_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [MASK_W-1:0] port_mask;
    logic              learned;
    logic              table_full;
  } out_item_t;

  typedef struct packed {
    cell_op_e          op;
    logic              alloc;
    logic [MAC_W-1:0]  key;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] expiry;
    logic [TIME_W-1:0] now;
  } cell_ctrl_t;

  // Carried from cell to cell: a hit seen so far with its port, and
  // whether a free entry has been seen so far.
  typedef struct packed {
    logic              hit;
    logic [PORT_W-1:0] port;
    logic              free;
  } cell_chain_t;

endpackage

// ===== sv/mlf_if.sv =====
interface mlf_in_if;
  logic              valid;
  logic              ready;
  mlf_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mlf_out_if;
  logic               valid;
  logic               ready;
  mlf_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mlf_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mlf_pkg::LIFE_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/mlf_cell.sv =====
module mlf_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mlf_pkg::cell_ctrl_t  ctrl_i,
  input  mlf_pkg::cell_chain_t chain_i,
  output mlf_pkg::cell_chain_t chain_o
);

  logic                       valid_q, valid_d;
  logic                       hit_q, hit_d;
  logic [mlf_pkg::MAC_W-1:0]  mac_q, mac_d;
  logic [mlf_pkg::PORT_W-1:0] port_q, port_d;
  logic [mlf_pkg::TIME_W-1:0] expiry_q, expiry_d;
  logic                       grant;

  // The lowest free entry is the first invalid one that sees no free entry ahead.
  assign grant = !valid_q && !chain_i.free;

  assign chain_o.hit  = chain_i.hit | hit_q;
  assign chain_o.port = hit_q ? port_q : chain_i.port;
  assign chain_o.free = chain_i.free | !valid_q;

  always_comb begin
    valid_d  = valid_q;
    hit_d    = hit_q;
    mac_d    = mac_q;
    port_d   = port_q;
    expiry_d = expiry_q;
    case (ctrl_i.op)
      mlf_pkg::CELL_COMPARE: begin
        hit_d = valid_q && (mac_q == ctrl_i.key);
      end
      mlf_pkg::CELL_UPDATE: begin
        if (hit_q) begin
          port_d   = ctrl_i.port;
          expiry_d = ctrl_i.expiry;
        end else if (ctrl_i.alloc && grant) begin
          valid_d  = 1'b1;
          mac_d    = ctrl_i.key;
          port_d   = ctrl_i.port;
          expiry_d = ctrl_i.expiry;
        end
      end
      mlf_pkg::CELL_AGE: begin
        if (valid_q && (expiry_q < ctrl_i.now)) begin
          valid_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mac_q    <= mac_d;
    port_q   <= port_d;
    expiry_q <= expiry_d;
  end

endmodule

// ===== sv/mlf_table.sv =====
module mlf_table (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mlf_pkg::cell_ctrl_t  ctrl_i,
  output mlf_pkg::cell_chain_t chain_o
);

  mlf_pkg::cell_chain_t link [mlf_pkg::TABLE_DEPTH+1];

  assign link[0] = '0;

  for (genvar i = 0; i < mlf_pkg::TABLE_DEPTH; i++) begin : g_cell
    mlf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl_i),
      .chain_i (link[i]),
      .chain_o (link[i+1])
    );
  end

  assign chain_o = link[mlf_pkg::TABLE_DEPTH];

endmodule

// ===== sv/mac_learning_forwarder.sv =====
// Learning layer-2 forwarding decision block. Each input word is a command:
// packet, one-second tick, loop probe, detection start or detection done;
// every word gives exactly one result word. The MAC table is a row of
// TABLE_DEPTH cells, each holding one entry and comparing it against a
// broadcast key; hit, port and free-entry flags ripple from cell to cell,
// which also picks the lowest free entry for a new source MAC. The block
// handles one word at a time: a packet that is learned and looked up passes
// through decode, source compare, write, destination compare, resolve and
// output; a tick passes through decode, an aging pass over all cells and
// output; and all other words pass through decode and output. The block is
// ready again in the cycle after the output step, which waits while an
// earlier result is still held. The result sits in an output register, so
// the next word is taken while it waits.
// The user must write mac_lifetime through the configuration channel only
// while the block is idle; the block itself does not enforce this.
// The table starts empty out of reset.
module mac_learning_forwarder (
  input logic      clk_i,
  input logic      rst_ni,
  mlf_in_if.sink   in_i,
  mlf_out_if.source out_o,
  mlf_cfg_if.sink  cfg_i
);

  mlf_pkg::state_e    state_q, state_d;
  mlf_pkg::in_item_t  item_q;
  mlf_pkg::out_item_t res_q, res_d;
  mlf_pkg::out_item_t out_q;
  logic               out_valid_q, out_valid_d;
  logic [mlf_pkg::TIME_W-1:0] now_q, now_d;
  logic [mlf_pkg::MASK_W-1:0] blocked_q, blocked_d;
  logic                       done_q, done_d;
  logic [mlf_pkg::LIFE_W-1:0] lifetime_q;

  mlf_pkg::cell_ctrl_t  ctrl;
  mlf_pkg::cell_chain_t chain;

  logic                       in_fire;
  logic                       out_free;
  logic [mlf_pkg::MASK_W-1:0] pbit;
  logic [mlf_pkg::TIME_W:0]   exp_sum;
  logic [mlf_pkg::TIME_W-1:0] expiry;

  assign in_i.ready  = (state_q == mlf_pkg::ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
  assign out_free    = !out_valid_q || out_o.ready;

  assign pbit    = mlf_pkg::MASK_W'(1) << item_q.in_port;
  assign exp_sum = {1'b0, now_q} + {{(mlf_pkg::TIME_W + 1 - mlf_pkg::LIFE_W){1'b0}}, lifetime_q};
  assign expiry  = exp_sum[mlf_pkg::TIME_W] ? mlf_pkg::TIME_MAX : exp_sum[mlf_pkg::TIME_W-1:0];

  mlf_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .chain_o (chain)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mlf_pkg::ST_IDLE: begin
        if (in_fire) state_d = mlf_pkg::ST_DECODE;
      end
      mlf_pkg::ST_DECODE: begin
        case (item_q.cmd)
          mlf_pkg::CMD_PACKET: begin
            if (done_q && ((blocked_q & pbit & mlf_pkg::PORTS_ALL) == '0)) begin
              state_d = mlf_pkg::ST_LEARN_CMP;
            end else begin
              state_d = mlf_pkg::ST_EMIT;
            end
          end
          mlf_pkg::CMD_TICK: state_d = mlf_pkg::ST_AGE;
          default:           state_d = mlf_pkg::ST_EMIT;
        endcase
      end
      mlf_pkg::ST_LEARN_CMP: state_d = mlf_pkg::ST_LEARN_WR;
      mlf_pkg::ST_LEARN_WR:  state_d = mlf_pkg::ST_LOOK_CMP;
      mlf_pkg::ST_LOOK_CMP:  state_d = mlf_pkg::ST_LOOK_RES;
      mlf_pkg::ST_LOOK_RES:  state_d = mlf_pkg::ST_EMIT;
      mlf_pkg::ST_AGE:       state_d = mlf_pkg::ST_EMIT;
      mlf_pkg::ST_EMIT: begin
        if (out_free) state_d = mlf_pkg::ST_IDLE;
      end
      default: state_d = mlf_pkg::ST_IDLE;
    endcase
  end

  // Datapath and cell control.
  always_comb begin
    res_d       = res_q;
    now_d       = now_q;
    blocked_d   = blocked_q;
    done_d      = done_q;
    out_valid_d = out_valid_q && !out_o.ready;
    ctrl.op     = mlf_pkg::CELL_HOLD;
    ctrl.alloc  = !chain.hit;
    ctrl.key    = item_q.src_mac;
    ctrl.port   = item_q.in_port;
    ctrl.expiry = expiry;
    ctrl.now    = now_q;
    case (state_q)
      mlf_pkg::ST_DECODE: begin
        res_d = '0;
        case (item_q.cmd)
          mlf_pkg::CMD_PACKET: begin
            if (!done_q) begin
              res_d.action = mlf_pkg::ACT_NOT_READY;
            end else if ((blocked_q & pbit & mlf_pkg::PORTS_ALL) != '0) begin
              res_d.action = mlf_pkg::ACT_BLOCKED;
            end
          end
          mlf_pkg::CMD_TICK: begin
            if (now_q != mlf_pkg::TIME_MAX) now_d = now_q + mlf_pkg::TIME_W'(1);
          end
          mlf_pkg::CMD_PROBE:     blocked_d = (blocked_q | pbit) & mlf_pkg::PORTS_ALL;
          mlf_pkg::CMD_DET_START: blocked_d = '0;
          mlf_pkg::CMD_DET_DONE:  done_d = 1'b1;
          default: begin
          end
        endcase
      end
      mlf_pkg::ST_LEARN_CMP: begin
        ctrl.op = mlf_pkg::CELL_COMPARE;
      end
      mlf_pkg::ST_LEARN_WR: begin
        ctrl.op = mlf_pkg::CELL_UPDATE;
        if (chain.hit) begin
          res_d.learned = (chain.port != item_q.in_port);
        end else begin
          res_d.learned    = chain.free;
          res_d.table_full = !chain.free;
        end
      end
      mlf_pkg::ST_LOOK_CMP: begin
        ctrl.op  = mlf_pkg::CELL_COMPARE;
        ctrl.key = item_q.dst_mac;
      end
      mlf_pkg::ST_LOOK_RES: begin
        if (!chain.hit) begin
          res_d.action    = mlf_pkg::ACT_FLOOD;
          res_d.port_mask = mlf_pkg::PORTS_ALL & ~pbit & ~blocked_q;
        end else if (chain.port == item_q.in_port) begin
          res_d.action = mlf_pkg::ACT_SAME_PORT;
        end else begin
          res_d.action    = mlf_pkg::ACT_UNICAST;
          res_d.port_mask = mlf_pkg::MASK_W'(1) << chain.port;
        end
      end
      mlf_pkg::ST_AGE: begin
        ctrl.op = mlf_pkg::CELL_AGE;
      end
      mlf_pkg::ST_EMIT: begin
        if (out_free) out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      now_q       <= '0;
      blocked_q   <= '0;
      done_q      <= 1'b0;
      lifetime_q  <= mlf_pkg::LIFE_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      now_q       <= now_d;
      blocked_q   <= blocked_d;
      done_q      <= done_d;
      if (cfg_i.valid && cfg_i.ready) lifetime_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) item_q <= in_i.data;
    res_q <= res_d;
    if (state_q == mlf_pkg::ST_EMIT && out_free) out_q <= res_q;
  end

endmodule
